// ===== rtl/drpt_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the dead reckoning tracker.
// Used by every module of the block; depends on nothing.

package drpt_pkg;

   localparam logic [15:0] GRAVITY_GAIN = 16'd2511;

   // Queue between front and back; depth must stay a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Width of gravity times acceleration, and of the shared multiplier operands.
   localparam int GA_W  = 33;
   localparam int MUL_W = 33;

   // Register byte addresses are 4 * index.
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_MODE          = 3'd0;
   localparam logic [2:0] REG_SPEED_LIMIT   = 3'd1;
   localparam logic [2:0] REG_POSITION_GAIN = 3'd2;
   localparam logic [2:0] REG_WALK_SPEED    = 3'd3;
   localparam logic [2:0] REG_MIN_X         = 3'd4;
   localparam logic [2:0] REG_MAX_X         = 3'd5;
   localparam logic [2:0] REG_MIN_Y         = 3'd6;
   localparam logic [2:0] REG_MAX_Y         = 3'd7;

   typedef enum logic [1:0] {
      KIND_RUN,    // mode 0, moving: integrate acceleration
      KIND_STILL,  // mode 0, at rest: zero velocity
      KIND_WALK,   // mode 1, moving: heading step
      KIND_HOLD    // mode 1, at rest: position unchanged
   } kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PROD,
      BK_VEL,
      BK_MOVE,
      BK_POS
   } back_state_type;

   typedef struct packed {
      kind_type                 kind;
      logic [15:0]              dt;
      logic signed [GA_W-1:0]   ga_x;
      logic signed [GA_W-1:0]   ga_y;
      logic [31:0]              scale;   // gain*dt in mode 0, walk_speed*dt in mode 1
      logic signed [15:0]       trig_x;
      logic signed [15:0]       trig_y;
   } entry_type;

   typedef struct packed {
      logic prod_en;
      logic move_sel;
      logic vel_en;
      logic pos_en;
   } lane_ctrl_type;

   typedef logic [14:0] sine_rom_type [0:255];

   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] Q30_HALF = 64'd536870912;

   // round(16384 * sin(j*pi/512)) by the integer Taylor series in Q30.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      for (int j = 0; j < 256; j++) begin
         x    = (64'(j) * PI_Q30) >> 9;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rom[j] = 15'((sum * 64'd16384 + Q30_HALF) >> 30);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Signed Q1.14 sine of a 16-bit heading; the low 6 bits are dropped.
   function automatic logic signed [15:0] sine_q14(input logic [15:0] h);
      logic [1:0]  q;
      logic [7:0]  f;
      logic [8:0]  idx;
      logic [14:0] mag;
      q   = h[15:14];
      f   = h[13:6];
      idx = q[0] ? (9'd256 - {1'b0, f}) : {1'b0, f};
      mag = idx[8] ? 15'd16384 : SINE_ROM[idx[7:0]];
      return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

// ===== rtl/drpt_front.sv =====
// Front end: accepts samples, classifies them and precomputes per-sample factors.
// Depends on drpt_pkg; feeds drpt_queue.

module drpt_front (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic signed [15:0]  accel_x,
   input  logic signed [15:0]  accel_y,
   input  logic [15:0]         heading,
   input  logic [15:0]         elapsed,
   input  logic                stationary,
   input  logic                mode,
   input  logic [15:0]         position_gain,
   input  logic [15:0]         walk_speed,
   input  logic                queue_full,
   output logic                push,
   output drpt_pkg::entry_type push_entry
);

   logic signed [16:0] gravity;
   logic [15:0]        factor;

   assign gravity    = $signed({1'b0, drpt_pkg::GRAVITY_GAIN});
   assign factor     = mode ? walk_speed : position_gain;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      if (mode) begin
         push_entry.kind = stationary ? drpt_pkg::KIND_HOLD : drpt_pkg::KIND_WALK;
      end else begin
         push_entry.kind = stationary ? drpt_pkg::KIND_STILL : drpt_pkg::KIND_RUN;
      end
      push_entry.dt     = elapsed;
      push_entry.ga_x   = gravity * accel_x;
      push_entry.ga_y   = gravity * accel_y;
      push_entry.scale  = 32'(factor) * 32'(elapsed);
      // x follows sine, y follows cosine (a quarter turn ahead)
      push_entry.trig_x = drpt_pkg::sine_q14(heading);
      push_entry.trig_y = drpt_pkg::sine_q14(heading + 16'd16384);
   end

endmodule

// ===== rtl/drpt_queue.sv =====
// Short FIFO of classified samples between front and back.
// Depends on drpt_pkg for the entry type and depth.

module drpt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  drpt_pkg::entry_type push_entry,
   input  logic                pop,
   output drpt_pkg::entry_type head,
   output logic                full,
   output logic                head_valid,
   output logic                head_more
);

   localparam int AW = drpt_pkg::QUEUE_AW;

   drpt_pkg::entry_type mem_ff [0:drpt_pkg::QUEUE_DEPTH-1];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [AW:0]         count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign full       = (count_ff == (AW+1)'(drpt_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_more  = (count_ff > (AW+1)'(1));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/drpt_axis.sv =====
// One axis of the back end: shared multiplier, velocity and position state.
// Depends on drpt_pkg; sequenced by drpt_back.

module drpt_axis (
   input  logic                       clock,
   input  logic                       reset,
   input  drpt_pkg::lane_ctrl_type    ctrl,
   input  drpt_pkg::kind_type         kind,
   input  logic [15:0]                dt,
   input  logic signed [drpt_pkg::GA_W-1:0] ga,
   input  logic [31:0]                scale,
   input  logic signed [15:0]         trig,
   input  logic [30:0]                speed_limit,
   input  logic signed [31:0]         bound_lo,
   input  logic signed [31:0]         bound_hi,
   output logic signed [31:0]         pos_next
);

   localparam int MW = drpt_pkg::MUL_W;

   logic signed [MW-1:0]   mul_a;
   logic signed [MW-1:0]   mul_b;
   logic signed [2*MW-1:0] mul_p;
   logic signed [63:0]     prod_ff;
   logic signed [31:0]     vel_ff, vel_in;
   logic signed [31:0]     place_ff, place_in;
   logic signed [63:0]     vel_shift;
   logic signed [63:0]     pos_shift;
   logic signed [33:0]     vel_sum;
   logic signed [33:0]     pos_sum;
   logic signed [31:0]     vel_sat;
   logic signed [31:0]     pos_sat;
   logic signed [32:0]     limit;
   logic signed [32:0]     vel_wide;
   logic signed [31:0]     vel_clamped;
   logic signed [31:0]     pos_bounded;
   logic                   walk;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   assign walk = (kind == drpt_pkg::KIND_WALK);

   // Operand select: acceleration or heading step first, then velocity for the mode 0 move.
   always_comb begin
      if (ctrl.move_sel) begin
         mul_a = {{(MW-32){vel_ff[31]}}, vel_ff};
         mul_b = {{(MW-32){1'b0}}, scale};
      end else if (walk) begin
         mul_a = {{(MW-16){trig[15]}}, trig};
         mul_b = {{(MW-32){1'b0}}, scale};
      end else begin
         mul_a = ga;
         mul_b = {{(MW-16){1'b0}}, dt};
      end
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      vel_shift = prod_ff >>> 20;
      vel_sum   = {{2{vel_ff[31]}}, vel_ff} + vel_shift[33:0];
      vel_sat   = sat32(vel_sum);
      limit     = $signed({2'b00, speed_limit});
      vel_wide  = {vel_sat[31], vel_sat};
      if (vel_wide > limit) begin
         vel_clamped = limit[31:0];
      end else if (vel_wide < -limit) begin
         vel_clamped = 32'(-limit);
      end else begin
         vel_clamped = vel_sat;
      end
      vel_in = (kind == drpt_pkg::KIND_STILL) ? 32'sd0 : vel_clamped;
   end

   always_comb begin
      pos_shift = walk ? (prod_ff >>> 38) : (prod_ff >>> 40);
      pos_sum   = {{2{place_ff[31]}}, place_ff} + pos_shift[33:0];
      pos_sat   = sat32(pos_sum);
      // minimum test wins when the bounds cross
      if (pos_sat < bound_lo) begin
         pos_bounded = bound_lo;
      end else if (pos_sat > bound_hi) begin
         pos_bounded = bound_hi;
      end else begin
         pos_bounded = pos_sat;
      end
      pos_next = (kind == drpt_pkg::KIND_HOLD) ? place_ff : pos_bounded;
      place_in = pos_next;
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= mul_p[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff   <= '0;
         place_ff <= '0;
      end else begin
         if (ctrl.vel_en) begin
            vel_ff <= vel_in;
         end
         if (ctrl.pos_en) begin
            place_ff <= place_in;
         end
      end
   end

endmodule

// ===== rtl/drpt_back.sv =====
// Back end: sequencer over the two axis lanes and the result register.
// Depends on drpt_pkg and drpt_axis.

module drpt_back (
   input  logic                clock,
   input  logic                reset,
   input  drpt_pkg::entry_type head,
   input  logic                head_valid,
   input  logic                head_more,
   output logic                pop,
   input  logic [30:0]         speed_limit,
   input  logic signed [31:0]  min_x,
   input  logic signed [31:0]  max_x,
   input  logic signed [31:0]  min_y,
   input  logic signed [31:0]  max_y,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata
);

   drpt_pkg::back_state_type state_ff, state_in;
   drpt_pkg::lane_ctrl_type  ctrl;
   logic                     out_free;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]              rsp_tdata_ff;
   logic signed [31:0]       pos_x_next;
   logic signed [31:0]       pos_y_next;
   logic                     zupt;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign zupt     = (head.kind == drpt_pkg::KIND_RUN) || (head.kind == drpt_pkg::KIND_STILL);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drpt_pkg::BK_IDLE: begin
            if (head_valid) begin
               state_in = drpt_pkg::BK_PROD;
            end
         end
         drpt_pkg::BK_PROD: begin
            state_in = zupt ? drpt_pkg::BK_VEL : drpt_pkg::BK_POS;
         end
         drpt_pkg::BK_VEL: begin
            state_in = drpt_pkg::BK_MOVE;
         end
         drpt_pkg::BK_MOVE: begin
            state_in = drpt_pkg::BK_POS;
         end
         drpt_pkg::BK_POS: begin
            if (out_free) begin
               state_in = head_more ? drpt_pkg::BK_PROD : drpt_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = drpt_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.prod_en  = (state_ff == drpt_pkg::BK_PROD) || (state_ff == drpt_pkg::BK_MOVE);
      ctrl.move_sel = (state_ff == drpt_pkg::BK_MOVE);
      ctrl.vel_en   = (state_ff == drpt_pkg::BK_VEL);
      ctrl.pos_en   = (state_ff == drpt_pkg::BK_POS) && out_free;
      pop           = ctrl.pos_en;
   end

   drpt_axis u_axis_x (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .kind        (head.kind),
      .dt          (head.dt),
      .ga          (head.ga_x),
      .scale       (head.scale),
      .trig        (head.trig_x),
      .speed_limit (speed_limit),
      .bound_lo    (min_x),
      .bound_hi    (max_x),
      .pos_next    (pos_x_next)
   );

   drpt_axis u_axis_y (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .kind        (head.kind),
      .dt          (head.dt),
      .ga          (head.ga_y),
      .scale       (head.scale),
      .trig        (head.trig_y),
      .speed_limit (speed_limit),
      .bound_lo    (min_y),
      .bound_hi    (max_y),
      .pos_next    (pos_y_next)
   );

   always_comb begin
      if (ctrl.pos_en) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.pos_en) begin
         rsp_tdata_ff <= {pos_y_next, pos_x_next};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= drpt_pkg::BK_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== rtl/dead_reckoning_position_tracker.sv =====
// Top level of the two-mode dead reckoning tracker: register file and channel wiring.
// Depends on drpt_pkg, drpt_front, drpt_queue and drpt_back.
//
//   Port group   Direction   Beat contents
//   req_*        in          one sensor sample (acceleration, heading, elapsed, rest flag)
//   rsp_*        out         one updated position (x, y) per sample
//   csr_*        in/out      register access, byte address 4 * register index
//
// Back-end steps per sample: mode 0 runs BK_PROD, BK_VEL, BK_MOVE and BK_POS (each axis
// lane owns one 33x33 multiplier, used once for acceleration times elapsed and once for the
// move); mode 1 runs BK_PROD and BK_POS (one multiply, one position update).
// BK_POS waits while the result register holds a beat that rsp_tready has not taken.
// The two-entry queue takes up to two more samples while the result register waits on
// rsp_tready; after that req_tready drops until the result beat leaves.
// Reset is synchronous: it clears velocity, position and queue and returns the registers
// to their defaults.

module dead_reckoning_position_tracker (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: accel_x[15:0], accel_y[31:16], heading[47:32], elapsed[63:48],
   // stationary[64], zero fill [71:65]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [71:0]                  req_tdata,
   // rsp_tdata: position_x[31:0], position_y[63:32]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [63:0]                  rsp_tdata,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [drpt_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic               mode_ff;
   logic [30:0]        speed_limit_ff;
   logic [15:0]        position_gain_ff;
   logic [15:0]        walk_speed_ff;
   logic signed [31:0] min_x_ff;
   logic signed [31:0] max_x_ff;
   logic signed [31:0] min_y_ff;
   logic signed [31:0] max_y_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   logic                push;
   drpt_pkg::entry_type push_entry;
   drpt_pkg::entry_type head;
   logic                queue_full;
   logic                head_valid;
   logic                head_more;
   logic                pop;

   // Register file: write on the access phase, pready always high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= 1'b0;
         speed_limit_ff   <= 31'd131072;
         position_gain_ff <= 16'd256;
         walk_speed_ff    <= 16'd358;
         min_x_ff         <= 32'sh8000_0000;
         max_x_ff         <= 32'sh7FFF_FFFF;
         min_y_ff         <= 32'sh8000_0000;
         max_y_ff         <= 32'sh7FFF_FFFF;
      end else if (csr_write) begin
         case (csr_index)
            drpt_pkg::REG_MODE:          mode_ff          <= csr_pwdata[0];
            drpt_pkg::REG_SPEED_LIMIT:   speed_limit_ff   <= csr_pwdata[30:0];
            drpt_pkg::REG_POSITION_GAIN: position_gain_ff <= csr_pwdata[15:0];
            drpt_pkg::REG_WALK_SPEED:    walk_speed_ff    <= csr_pwdata[15:0];
            drpt_pkg::REG_MIN_X:         min_x_ff         <= csr_pwdata;
            drpt_pkg::REG_MAX_X:         max_x_ff         <= csr_pwdata;
            drpt_pkg::REG_MIN_Y:         min_y_ff         <= csr_pwdata;
            drpt_pkg::REG_MAX_Y:         max_y_ff         <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // Read back zero-extended register values.
   always_comb begin
      case (csr_index)
         drpt_pkg::REG_MODE:          csr_prdata = {31'd0, mode_ff};
         drpt_pkg::REG_SPEED_LIMIT:   csr_prdata = {1'b0, speed_limit_ff};
         drpt_pkg::REG_POSITION_GAIN: csr_prdata = {16'd0, position_gain_ff};
         drpt_pkg::REG_WALK_SPEED:    csr_prdata = {16'd0, walk_speed_ff};
         drpt_pkg::REG_MIN_X:         csr_prdata = min_x_ff;
         drpt_pkg::REG_MAX_X:         csr_prdata = max_x_ff;
         drpt_pkg::REG_MIN_Y:         csr_prdata = min_y_ff;
         drpt_pkg::REG_MAX_Y:         csr_prdata = max_y_ff;
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // Front: classify the sample and precompute gravity, scale and trig factors.
   drpt_front u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .accel_x       (req_tdata[15:0]),
      .accel_y       (req_tdata[31:16]),
      .heading       (req_tdata[47:32]),
      .elapsed       (req_tdata[63:48]),
      .stationary    (req_tdata[64]),
      .mode          (mode_ff),
      .position_gain (position_gain_ff),
      .walk_speed    (walk_speed_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Queue: hold classified samples until the back end retires them.
   drpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_more  (head_more)
   );

   // Back: advance velocity and position, then drive the result register.
   drpt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (head_valid),
      .head_more   (head_more),
      .pop         (pop),
      .speed_limit (speed_limit_ff),
      .min_x       (min_x_ff),
      .max_x       (max_x_ff),
      .min_y       (min_y_ff),
      .max_y       (max_y_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== rtl/drpt_checker.sv =====
// Port-level checker for the dead reckoning tracker, bound to the top level.
// Depends on drpt_pkg for the queue depth.

module drpt_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [63:0]                  rsp_tdata
);

   logic [2:0] pending_ff, pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign pending_in = pending_ff + 3'(req_beat) - 3'(rsp_beat);

   // Count samples taken but not yet answered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result valid or input stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat dropped or changed");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 3'd0))
      else $error("result beat without an outstanding sample");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (pending_ff <= 3'(drpt_pkg::QUEUE_DEPTH)))
      else $error("input ready with the queue already full");

endmodule

bind dead_reckoning_position_tracker drpt_checker u_checker (.*);

// ===== bench/drpt_bench_pkg.sv =====
// Bench-side types and the tracker mirror class for the dead reckoning tracker bench.
// Depends on drpt_pkg for the register indexes and the gravity gain.

package drpt_bench_pkg;

   import drpt_pkg::*;

   localparam longint Q32_MAX = 64'sd2147483647;
   localparam longint Q32_MIN = -64'sd2147483648;
   localparam longint unsigned PI_Q30_U = 64'd3373259426;
   localparam longint unsigned HALF_Q30_U = 64'd536870912;

   // Same layout as req_tdata: accel_x lowest, stationary on top.
   typedef struct packed {
      logic        stationary;
      logic [15:0] elapsed;
      logic [15:0] heading;
      logic [15:0] accel_y;
      logic [15:0] accel_x;
   } sensor_sample_t;

   // Same layout as rsp_tdata: x in the low word.
   typedef struct packed {
      logic [31:0] y;
      logic [31:0] x;
   } fix_position_t;

   typedef struct {
      logic        mode;
      logic [30:0] speed_limit;
      logic [15:0] position_gain;
      logic [15:0] walk_speed;
      logic [31:0] min_x;
      logic [31:0] max_x;
      logic [31:0] min_y;
      logic [31:0] max_y;
   } tracker_setting_t;

   class tracker_mirror;
      logic            mode;
      longint          speed_limit;
      longint          position_gain;
      longint          walk_speed;
      longint          min_x, max_x, min_y, max_y;
      longint          vel_x, vel_y, pos_x, pos_y;
      longint          quarter_wave [0:256];
      fix_position_t   pending_positions [$];
      int              mismatch_count;
      int              results_seen;

      function new();
         longint unsigned x, x2, term, sum;
         for (int j = 0; j < 256; j++) begin
            x    = (64'(j) * PI_Q30_U) / 512;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++) begin
               term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
            quarter_wave[j] = longint'((sum * 16384 + HALF_Q30_U) >> 30);
         end
         quarter_wave[256] = 16384;
         mode           = 1'b0;
         speed_limit    = 131072;
         position_gain  = 256;
         walk_speed     = 358;
         min_x          = Q32_MIN;
         max_x          = Q32_MAX;
         min_y          = Q32_MIN;
         max_y          = Q32_MAX;
         vel_x          = 0;
         vel_y          = 0;
         pos_x          = 0;
         pos_y          = 0;
         mismatch_count = 0;
         results_seen   = 0;
      endfunction

      function longint sat32(longint v);
         if (v > Q32_MAX) return Q32_MAX;
         if (v < Q32_MIN) return Q32_MIN;
         return v;
      endfunction

      // Lower edge wins when the bounds cross.
      function longint bound(longint p, longint lo, longint hi);
         if (p < lo) return lo;
         if (p > hi) return hi;
         return p;
      endfunction

      function longint sine_q14(logic [15:0] h);
         logic [8:0] idx;
         idx = h[14] ? (9'd256 - {1'b0, h[13:6]}) : {1'b0, h[13:6]};
         return h[15] ? -quarter_wave[idx] : quarter_wave[idx];
      endfunction

      function longint velocity_update(longint v, longint a, longint dt, logic still);
         longint nv;
         if (still) begin
            nv = 0;
         end else begin
            nv = sat32(v + ((longint'(GRAVITY_GAIN) * a * dt) >>> 20));
         end
         if (nv > speed_limit) begin
            nv = speed_limit;
         end else if (nv < -speed_limit) begin
            nv = -speed_limit;
         end
         return nv;
      endfunction

      // Drop bits beyond each register's width, as the block does.
      function void write_register(logic [2:0] idx, logic [31:0] data);
         case (idx)
            REG_MODE:          mode = data[0];
            REG_SPEED_LIMIT:   speed_limit = longint'(data[30:0]);
            REG_POSITION_GAIN: position_gain = longint'(data[15:0]);
            REG_WALK_SPEED:    walk_speed = longint'(data[15:0]);
            REG_MIN_X:         min_x = longint'($signed(data));
            REG_MAX_X:         max_x = longint'($signed(data));
            REG_MIN_Y:         min_y = longint'($signed(data));
            REG_MAX_Y:         max_y = longint'($signed(data));
            default: ;
         endcase
      endfunction

      function void absorb_sample(sensor_sample_t s);
         longint        ax, ay, dt, gm, wd, sn, cs;
         fix_position_t next;
         ax = longint'($signed(s.accel_x));
         ay = longint'($signed(s.accel_y));
         dt = longint'(s.elapsed);
         if (mode == 1'b0) begin
            gm    = position_gain * dt;
            vel_x = velocity_update(vel_x, ax, dt, s.stationary);
            vel_y = velocity_update(vel_y, ay, dt, s.stationary);
            pos_x = bound(sat32(pos_x + ((gm * vel_x) >>> 40)), min_x, max_x);
            pos_y = bound(sat32(pos_y + ((gm * vel_y) >>> 40)), min_y, max_y);
         end else if (!s.stationary) begin
            sn    = sine_q14(s.heading);
            cs    = sine_q14(s.heading + 16'h4000);
            wd    = walk_speed * dt;
            pos_x = bound(sat32(pos_x + ((sn * wd) >>> 38)), min_x, max_x);
            pos_y = bound(sat32(pos_y + ((cs * wd) >>> 38)), min_y, max_y);
         end
         next.x = pos_x[31:0];
         next.y = pos_y[31:0];
         pending_positions.push_back(next);
      endfunction

      task flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
         mismatch_count++;
         $display("mismatch on %s at result %0d: expected %h, got %h",
                  field, results_seen, want, got);
      endtask

      task compare_position(fix_position_t got);
         fix_position_t want;
         results_seen++;
         if (pending_positions.size() == 0) begin
            flag_mismatch("result beat with no sample pending", 32'd0, got.x);
            return;
         end
         want = pending_positions.pop_front();
         if (got.x !== want.x) flag_mismatch("position_x", want.x, got.x);
         if (got.y !== want.y) flag_mismatch("position_y", want.y, got.y);
      endtask
   endclass

endpackage

// ===== bench/testbench.sv =====
// Top of the dead reckoning tracker bench: clock, reset, stimulus and result checking.
// Depends on drpt_pkg, drpt_bench_pkg and the dead_reckoning_position_tracker RTL.

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import drpt_pkg::*;
   import drpt_bench_pkg::*;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   // req_tdata: accel_x, accel_y, heading, elapsed, stationary, zero fill (lowest first)
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [71:0]         req_tdata   = '0;
   // rsp_tdata: position_x, position_y (lowest first)
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [63:0]         rsp_tdata;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [31:0]         csr_pwdata  = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // Set while both sides must run without any idle cycle.
   bit                  calm = 1'b0;

   tracker_mirror       tracker = new();

   dead_reckoning_position_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 0;
   end

   // Hard stop in case a beat never arrives.
   initial begin
      #2ms;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic sensor_sample_t make_sample(logic [15:0] ax, logic [15:0] ay,
                                                 logic [15:0] h, logic [15:0] dt,
                                                 logic still);
      sensor_sample_t s;
      s.accel_x    = ax;
      s.accel_y    = ay;
      s.heading    = h;
      s.elapsed    = dt;
      s.stationary = still;
      return s;
   endfunction

   // Pull acceleration toward a bias so velocity can build up over a phase;
   // long_steps pins elapsed at its maximum to reach saturation sooner.
   function automatic sensor_sample_t random_sample(logic [15:0] bias_x, logic [15:0] bias_y,
                                                   int bias_pct, int still_pct,
                                                   bit long_steps);
      sensor_sample_t s;
      s.accel_x = ($urandom_range(99) < bias_pct) ? bias_x : 16'($urandom);
      s.accel_y = ($urandom_range(99) < bias_pct) ? bias_y : 16'($urandom);
      s.heading = 16'($urandom);
      case ($urandom_range(9))
         0:       s.elapsed = 16'h0000;
         1:       s.elapsed = 16'hFFFF;
         default: s.elapsed = 16'($urandom);
      endcase
      if (long_steps) s.elapsed = 16'hFFFF;
      s.stationary = ($urandom_range(99) < still_pct);
      return s;
   endfunction

   // Pick a bound pair: full range, tight around zero, ordered, or in either
   // order so that crossed bounds show up too.
   function automatic void random_bounds(output logic [31:0] lo, output logic [31:0] hi);
      logic [31:0] a;
      logic [31:0] b;
      a = $urandom;
      b = $urandom;
      case ($urandom_range(3))
         0: begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
         end
         1: begin
            lo = -32'($urandom_range(1 << 22));
            hi = 32'($urandom_range(1 << 22));
         end
         2: begin
            if ($signed(a) > $signed(b)) begin
               lo = b;
               hi = a;
            end else begin
               lo = a;
               hi = b;
            end
         end
         default: begin
            lo = a;
            hi = b;
         end
      endcase
   endfunction

   function automatic tracker_setting_t random_config();
      tracker_setting_t c;
      c.mode = 1'($urandom_range(1));
      case ($urandom_range(3))
         0:       c.speed_limit = 31'd0;
         1:       c.speed_limit = 31'h7FFF_FFFF;
         2:       c.speed_limit = 31'($urandom_range(1 << 20));
         default: c.speed_limit = 31'($urandom);
      endcase
      case ($urandom_range(2))
         0:       c.position_gain = 16'd0;
         1:       c.position_gain = 16'hFFFF;
         default: c.position_gain = 16'($urandom);
      endcase
      case ($urandom_range(2))
         0:       c.walk_speed = 16'd0;
         1:       c.walk_speed = 16'hFFFF;
         default: c.walk_speed = 16'($urandom);
      endcase
      random_bounds(c.min_x, c.max_x);
      random_bounds(c.min_y, c.max_y);
      return c;
   endfunction

   // Run the setup phase and then the access phase; leave psel high so that a following
   // write does not lower and raise it within one step.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_register(idx, data);
   endtask

   // Write every register, with random junk above each register's width.
   task automatic write_config(input tracker_setting_t c);
      write_reg(REG_MODE,          {31'($urandom), c.mode});
      write_reg(REG_SPEED_LIMIT,   {1'($urandom), c.speed_limit});
      write_reg(REG_POSITION_GAIN, {16'($urandom), c.position_gain});
      write_reg(REG_WALK_SPEED,    {16'($urandom), c.walk_speed});
      write_reg(REG_MIN_X,         c.min_x);
      write_reg(REG_MAX_X,         c.max_x);
      write_reg(REG_MIN_Y,         c.min_y);
      write_reg(REG_MAX_Y,         c.max_y);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one sample beat, maybe after a random idle gap; junk rides on
   // tdata while valid is low. Note the sample at the accepting edge.
   task automatic send_sample(input sensor_sample_t s);
      if (!calm && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {8'($urandom), $urandom, $urandom};
         do @(posedge clock); while (!calm && $urandom_range(99) < 22);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, s};
      do @(posedge clock); while (!req_tready);
      tracker.absorb_sample(s);
   endtask

   // Drop valid and hold until every expected position has come back; the
   // block is then idle, since each sample yields exactly one beat.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_positions.size() != 0);
   endtask

   // Result side: check each accepted beat, then pick the next ready value.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            tracker.compare_position(fix_position_t'(rsp_tdata));
         end
         rsp_tready <= calm || ($urandom_range(99) >= 22);
      end
   end

   initial begin
      tracker_setting_t setting;
      logic [15:0]      bias_x;
      logic [15:0]      bias_y;
      int               bias_pct;
      int               still_pct;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, mode 0: accel extremes against the 2 m/s velocity
      // clamp, a zero time step, and a rest sample that zeroes velocity.
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0));
      send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_sample(make_sample(16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF, 1'b0));
      drain_results();

      // Mode 1 with full walk speed inside a one-metre box: every quadrant,
      // the last table index, and a rest sample that holds position.
      setting = '{mode: 1'b1, speed_limit: 31'h7FFF_FFFF, position_gain: 16'hFFFF,
                  walk_speed: 16'hFFFF, min_x: -32'sh10000, max_x: 32'h10000,
                  min_y: -32'sh8000, max_y: 32'h8000};
      write_config(setting);
      send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h0000, 16'h0000, 16'hC000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h3FC0, 16'h8000, 1'b0));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b1));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0));
      drain_results();

      // Mode 0 with crossed x bounds, where the lower edge wins, and a full
      // range y axis; maximum gain and the widest velocity limit.
      setting = '{mode: 1'b0, speed_limit: 31'h7FFF_FFFF, position_gain: 16'hFFFF,
                  walk_speed: 16'h0000, min_x: 32'h1000, max_x: -32'sh1000,
                  min_y: 32'h8000_0000, max_y: 32'h7FFF_FFFF};
      write_config(setting);
      send_sample(make_sample(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0));
      send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b1));
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 1'b0));
      drain_results();

      // Ramp: push both velocities into 32-bit saturation under the widest
      // limit, so the position saturates as well.
      setting = '{mode: 1'b0, speed_limit: 31'h7FFF_FFFF, position_gain: 16'hFFFF,
                  walk_speed: 16'd358, min_x: 32'h8000_0000, max_x: 32'h7FFF_FFFF,
                  min_y: 32'h8000_0000, max_y: 32'h7FFF_FFFF};
      write_config(setting);
      repeat (500) send_sample(random_sample(16'h7FFF, 16'h8000, 100, 0, 1'b1));
      drain_results();

      // Random phases, each under a fresh random setting; one of them runs
      // with no idle cycle on either side.
      for (int phase = 0; phase < 9; phase++) begin
         write_config(random_config());
         calm      = (phase == 4);
         bias_x    = 16'($urandom);
         bias_y    = 16'($urandom);
         bias_pct  = $urandom_range(70);
         case ($urandom_range(2))
            0:       still_pct = 0;
            1:       still_pct = 5;
            default: still_pct = 25;
         endcase
         repeat (95) send_sample(random_sample(bias_x, bias_y, bias_pct, still_pct, 1'b0));
         drain_results();
         calm = 1'b0;
      end

      // Let any stray beat show up before the verdict.
      repeat (16) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_positions.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/drpt_pkg.sv
rtl/drpt_front.sv
rtl/drpt_queue.sv
rtl/drpt_axis.sv
rtl/drpt_back.sv
rtl/dead_reckoning_position_tracker.sv
rtl/drpt_checker.sv
bench/drpt_bench_pkg.sv
bench/testbench.sv
